// ===== rtl/core/ppp_pkg.sv =====
// Shared widths, register indexes and control types for the perspective
// point projection pipeline. No dependencies.
package ppp_pkg;

    // Field and datapath widths.
    localparam int CoordW = 32;
    localparam int RelW   = CoordW + 1;
    localparam int CoefW  = 16;
    localparam int ProdW  = RelW + CoefW;
    localparam int SumW   = ProdW + 2;
    localparam int MagW   = SumW;
    localparam int DenW   = SumW + 8;
    localparam int KW     = 35;
    localparam int BaseW  = 19;
    localparam int TermW  = MagW + KW;
    localparam int OffsW  = DenW + BaseW;
    localparam int MW     = TermW + 1;
    localparam int XW     = 96;
    localparam int QW     = 33;
    localparam int DataW  = 64;
    localparam int AddrW  = 6;

    // Register indexes on the configuration port.
    localparam logic [2:0] RegCameraX = 3'd0;
    localparam logic [2:0] RegCameraY = 3'd1;
    localparam logic [2:0] RegCameraZ = 3'd2;
    localparam logic [2:0] RegHorizCo = 3'd3;
    localparam logic [2:0] RegVertCo  = 3'd4;
    localparam logic [2:0] RegDepthCo = 3'd5;
    localparam logic [2:0] RegFocal   = 3'd6;
    localparam logic [2:0] RegScreen  = 3'd7;

    // Saturation limits of the 32-bit screen coordinates.
    localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
    localparam logic [31:0] SatMin = 32'h8000_0000;

    // Control that travels alongside each beat.
    typedef struct packed {
        logic valid;
        logic vis;
    } ppp_ctl_t;

endpackage

// ===== rtl/core/ppp_rotate.sv =====
// Camera translation, rotation dot products and depth test (four stages).
// Depends on ppp_pkg.
module ppp_rotate
    import ppp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     ce,
    input  logic                     i_valid,
    input  logic signed [CoordW-1:0] i_world_x,
    input  logic signed [CoordW-1:0] i_world_y,
    input  logic signed [CoordW-1:0] i_world_z,
    input  logic signed [CoordW-1:0] camera_x,
    input  logic signed [CoordW-1:0] camera_y,
    input  logic signed [CoordW-1:0] camera_z,
    input  logic [47:0]              horiz_coeffs,
    input  logic [47:0]              vert_coeffs,
    input  logic [47:0]              depth_coeffs,
    input  logic [15:0]              focal_factor,
    input  logic [31:0]              screen_size,
    output ppp_ctl_t                 o_ctl,
    output logic [MagW-1:0]          o_mag_x,
    output logic                     o_neg_x,
    output logic [MagW-1:0]          o_mag_y,
    output logic                     o_neg_y,
    output logic [DenW-1:0]          o_den,
    output logic [KW-1:0]            o_k,
    output logic [BaseW-1:0]         o_base_x,
    output logic [BaseW-1:0]         o_base_y
);

    logic [3:0]               valid_reg;
    logic signed [RelW-1:0]   rel_reg  [3];
    logic signed [RelW-1:0]   rel_next [3];
    logic signed [ProdW-1:0]  prod_reg  [3][3];
    logic signed [ProdW-1:0]  prod_next [3][3];
    logic signed [SumW-1:0]   sum_reg  [3];
    logic signed [SumW-1:0]   sum_next [3];
    logic [47:0]              coef_set [3];

    logic                     vis_reg, vis_next;
    logic [MagW-1:0]          mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic                     neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [DenW-1:0]          den_reg, den_next;
    logic [KW-1:0]            k_reg, k_next;
    logic [BaseW-1:0]         base_x_reg, base_x_next, base_y_reg, base_y_next;

    logic signed [59:0]       pz100;
    logic signed [SumW-1:0]   neg_pz;
    logic [31:0]              fh;

    assign coef_set[0] = horiz_coeffs;
    assign coef_set[1] = vert_coeffs;
    assign coef_set[2] = depth_coeffs;

    // Stage 1: position relative to the camera.
    always_comb begin
        rel_next[0] = RelW'(i_world_x) - RelW'(camera_x);
        rel_next[1] = RelW'(i_world_y) - RelW'(camera_y);
        rel_next[2] = RelW'(i_world_z) - RelW'(camera_z);
    end

    // Stage 2: the nine weight products.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[a][c] = ProdW'(rel_reg[c])
                                * ProdW'($signed(coef_set[a][CoefW*c +: CoefW]));
            end
        end
    end

    // Stage 3: the three dot product sums px, py and pz.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum_next[a] = SumW'(prod_reg[a][0]) + SumW'(prod_reg[a][1])
                        + SumW'(prod_reg[a][2]);
        end
    end

    // Stage 4: depth test, magnitudes, divisor and scale factors.
    always_comb begin
        pz100       = 60'(sum_reg[2]) * 60'sd100;
        vis_next    = (pz100 < -60'sd1073741824);
        neg_pz      = -sum_reg[2];
        den_next    = {neg_pz, 8'b0};
        neg_x_next  = sum_reg[0][SumW-1];
        mag_x_next  = sum_reg[0][SumW-1] ? MagW'(-sum_reg[0]) : MagW'(sum_reg[0]);
        neg_y_next  = !sum_reg[1][SumW-1] && (sum_reg[1] != '0);
        mag_y_next  = sum_reg[1][SumW-1] ? MagW'(-sum_reg[1]) : MagW'(sum_reg[1]);
        fh          = 32'(focal_factor) * 32'(screen_size[31:16]);
        k_next      = KW'({fh, 2'b00}) + KW'(fh);
        base_x_next = BaseW'({screen_size[15:0], 2'b00}) + BaseW'(screen_size[15:0]);
        base_y_next = BaseW'({screen_size[31:16], 2'b00}) + BaseW'(screen_size[31:16]);
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[2:0], i_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rel_reg    <= rel_next;
            prod_reg   <= prod_next;
            sum_reg    <= sum_next;
            vis_reg    <= vis_next;
            mag_x_reg  <= mag_x_next;
            mag_y_reg  <= mag_y_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            den_reg    <= den_next;
            k_reg      <= k_next;
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
        end
    end

    assign o_ctl.valid = valid_reg[3];
    assign o_ctl.vis   = vis_reg;
    assign o_mag_x     = mag_x_reg;
    assign o_neg_x     = neg_x_reg;
    assign o_mag_y     = mag_y_reg;
    assign o_neg_y     = neg_y_reg;
    assign o_den       = den_reg;
    assign o_k         = k_reg;
    assign o_base_x    = base_x_reg;
    assign o_base_y    = base_y_reg;

endmodule

// ===== rtl/core/ppp_scale.sv =====
// Perspective and offset products, signed combination and dividend setup
// for both screen axes (four stages). Depends on ppp_pkg.
module ppp_scale
    import ppp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  ppp_ctl_t         i_ctl,
    input  logic [MagW-1:0]  i_mag_x,
    input  logic             i_neg_x,
    input  logic [MagW-1:0]  i_mag_y,
    input  logic             i_neg_y,
    input  logic [DenW-1:0]  i_den,
    input  logic [KW-1:0]    i_k,
    input  logic [BaseW-1:0] i_base_x,
    input  logic [BaseW-1:0] i_base_y,
    output ppp_ctl_t         o_ctl,
    output logic [XW-1:0]    o_x_x,
    output logic [XW-1:0]    o_x_y,
    output logic             o_neg_x,
    output logic             o_neg_y,
    output logic [DenW-1:0]  o_den
);

    localparam int TL = KW + 32;
    localparam int TH = KW + MagW - 32;
    localparam int OL = BaseW + 32;
    localparam int OH = BaseW + DenW - 32;

    logic             valid_reg [4];
    logic             vis_reg [4];
    logic             neg_reg [4][2];
    logic [DenW-1:0]  den_reg [4];

    // Stage 5: partial products, cut at bit 32 of the wide operand.
    logic [TL-1:0]    tl_reg [2];
    logic [TH-1:0]    th_reg [2];
    logic [OL-1:0]    ol_reg [2];
    logic [OH-1:0]    oh_reg [2];
    // Stage 6: assembled terms.
    logic [TermW-1:0] term_reg [2];
    logic [OffsW-1:0] offs_reg [2];
    // Stage 7: combined magnitude.
    logic [MW-1:0]    m_reg [2];
    // Stage 8: rounding dividend.
    logic [XW-1:0]    x_reg [2];

    logic [MagW-1:0]  mag_in  [2];
    logic [BaseW-1:0] base_in [2];
    logic             neg_in  [2];
    logic [MW-1:0]    m_next  [2];
    logic             neg7_next [2];

    assign mag_in[0]  = i_mag_x;
    assign mag_in[1]  = i_mag_y;
    assign base_in[0] = i_base_x;
    assign base_in[1] = i_base_y;
    assign neg_in[0]  = i_neg_x;
    assign neg_in[1]  = i_neg_y;

    // Signed combination of offset and perspective term.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            neg7_next[a] = 1'b0;
            if (!neg_reg[1][a]) begin
                m_next[a] = MW'(offs_reg[a]) + MW'(term_reg[a]);
            end else if (MW'(offs_reg[a]) >= MW'(term_reg[a])) begin
                m_next[a] = MW'(offs_reg[a]) - MW'(term_reg[a]);
            end else begin
                m_next[a]    = MW'(term_reg[a]) - MW'(offs_reg[a]);
                neg7_next[a] = 1'b1;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 4; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (ce) begin
            valid_reg[0] <= i_ctl.valid;
            for (int s = 1; s < 4; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (ce) begin
            vis_reg[0] <= i_ctl.vis;
            den_reg[0] <= i_den;
            for (int s = 1; s < 4; s++) begin
                vis_reg[s] <= vis_reg[s-1];
                den_reg[s] <= den_reg[s-1];
            end
            for (int a = 0; a < 2; a++) begin
                neg_reg[0][a] <= neg_in[a];
                neg_reg[1][a] <= neg_reg[0][a];
                neg_reg[2][a] <= neg7_next[a];
                neg_reg[3][a] <= neg_reg[2][a];
                tl_reg[a]   <= TL'(mag_in[a][31:0]) * TL'(i_k);
                th_reg[a]   <= TH'(mag_in[a][MagW-1:32]) * TH'(i_k);
                ol_reg[a]   <= OL'(i_den[31:0]) * OL'(base_in[a]);
                oh_reg[a]   <= OH'(i_den[DenW-1:32]) * OH'(base_in[a]);
                term_reg[a] <= (TermW'(th_reg[a]) << 32) + TermW'(tl_reg[a]);
                offs_reg[a] <= (OffsW'(oh_reg[a]) << 32) + OffsW'(ol_reg[a]);
                m_reg[a]    <= m_next[a];
                x_reg[a]    <= XW'({m_reg[a], 1'b0}) + XW'(den_reg[2]);
            end
        end
    end

    assign o_ctl.valid = valid_reg[3];
    assign o_ctl.vis   = vis_reg[3];
    assign o_x_x       = x_reg[0];
    assign o_x_y       = x_reg[1];
    assign o_neg_x     = neg_reg[3][0];
    assign o_neg_y     = neg_reg[3][1];
    assign o_den       = den_reg[3];

endmodule

// ===== rtl/core/ppp_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, quotient of
// x by twice the divisor, with an overflow flag. Depends on ppp_pkg.
module ppp_divider
    import ppp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  ppp_ctl_t        i_ctl,
    input  logic            i_neg,
    input  logic [XW-1:0]   i_x,
    input  logic [DenW-1:0] i_den,
    output ppp_ctl_t        o_ctl,
    output logic            o_neg,
    output logic            o_sat,
    output logic [QW-1:0]   o_q
);

    ppp_ctl_t        ctl_reg [QW+1];
    logic            neg_reg [QW+1];
    logic            sat_reg [QW+1];
    logic [XW-1:0]   x_reg   [QW+1];
    logic [DenW-1:0] den_reg [QW+1];
    logic [QW-1:0]   q_reg   [QW+1];

    // Entry stage: overflow when the quotient would reach two to the QW.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0].valid <= 1'b0;
        end else if (ce) begin
            ctl_reg[0].valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl_reg[0].vis <= i_ctl.vis;
            neg_reg[0]     <= i_neg;
            sat_reg[0]     <= (i_x >= (XW'(i_den) << (QW + 1)));
            x_reg[0]       <= i_x;
            den_reg[0]     <= i_den;
            q_reg[0]       <= '0;
        end
    end

    // One stage per quotient bit, most significant first.
    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic [XW-1:0] ys;
        logic          hit;

        assign ys  = XW'(den_reg[j]) << (B + 1);
        assign hit = (x_reg[j] >= ys);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j+1].valid <= 1'b0;
            end else if (ce) begin
                ctl_reg[j+1].valid <= ctl_reg[j].valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                ctl_reg[j+1].vis <= ctl_reg[j].vis;
                neg_reg[j+1]     <= neg_reg[j];
                sat_reg[j+1]     <= sat_reg[j];
                den_reg[j+1]     <= den_reg[j];
                x_reg[j+1]       <= hit ? (x_reg[j] - ys) : x_reg[j];
                q_reg[j+1]       <= q_reg[j] | (QW'(hit) << B);
            end
        end
    end

    assign o_ctl = ctl_reg[QW];
    assign o_neg = neg_reg[QW];
    assign o_sat = sat_reg[QW];
    assign o_q   = q_reg[QW];

endmodule

// ===== rtl/core/perspective_point_projection.sv =====
// Top level of the perspective point projection block: register file,
// stream ports and the pipeline. Depends on ppp_pkg and all ppp_ modules.
//
// One world point enters per clock unless the output stalls, and one result beat
// leaves per point after four stages for translation, rotation and depth test,
// four for the perspective products and rounding setup, 34 for the
// bit-per-stage dividers, and the output register. The divider pipeline
// is the deepest part. Throughput is one point per cycle while the output
// does not stall. The whole pipeline holds while the output beat waits,
// so s_tready follows m_tready when the output register is full.
// Configuration should only be written while no point is in flight.
module perspective_point_projection
    import ppp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Input points.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [95:0]      s_tdata,   // world_x, world_y, world_z
    // Results.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // screen_x_tenths, screen_y_tenths
    output logic             m_tuser,   // visible
    // Configuration.
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    logic [31:0] camera_x_reg, camera_y_reg, camera_z_reg;
    logic [47:0] horiz_reg, vert_reg, depth_reg;
    logic [15:0] focal_reg;
    logic [31:0] screen_reg;
    logic [2:0]  reg_idx;

    logic        ce;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    ppp_ctl_t         rot_ctl, scl_ctl, dvx_ctl, dvy_ctl;
    logic [MagW-1:0]  mag_x, mag_y;
    logic             neg_x, neg_y, sneg_x, sneg_y, qneg_x, qneg_y, sat_x, sat_y;
    logic [DenW-1:0]  den, sden;
    logic [KW-1:0]    k;
    logic [BaseW-1:0] base_x, base_y;
    logic [XW-1:0]    x_x, x_y;
    logic [QW-1:0]    q_x, q_y;
    logic [31:0]      coord_x, coord_y;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_x_reg <= '0;
            camera_y_reg <= '0;
            camera_z_reg <= '0;
            horiz_reg    <= 48'd16384;
            vert_reg     <= 48'd1073741824;
            depth_reg    <= 48'd70368744177664;
            focal_reg    <= 16'd256;
            screen_reg   <= 32'd70780800;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                RegCameraX: camera_x_reg <= pwdata[31:0];
                RegCameraY: camera_y_reg <= pwdata[31:0];
                RegCameraZ: camera_z_reg <= pwdata[31:0];
                RegHorizCo: horiz_reg    <= pwdata[47:0];
                RegVertCo:  vert_reg     <= pwdata[47:0];
                RegDepthCo: depth_reg    <= pwdata[47:0];
                RegFocal:   focal_reg    <= pwdata[15:0];
                RegScreen:  screen_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            RegCameraX: prdata = DataW'(camera_x_reg);
            RegCameraY: prdata = DataW'(camera_y_reg);
            RegCameraZ: prdata = DataW'(camera_z_reg);
            RegHorizCo: prdata = DataW'(horiz_reg);
            RegVertCo:  prdata = DataW'(vert_reg);
            RegDepthCo: prdata = DataW'(depth_reg);
            RegFocal:   prdata = DataW'(focal_reg);
            RegScreen:  prdata = DataW'(screen_reg);
            default:    prdata = '0;
        endcase
    end

    // The pipeline advances whenever the output register can take a beat.
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    ppp_rotate u_rotate (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ce           (ce),
        .i_valid      (s_tvalid),
        .i_world_x    ($signed(s_tdata[31:0])),
        .i_world_y    ($signed(s_tdata[63:32])),
        .i_world_z    ($signed(s_tdata[95:64])),
        .camera_x     ($signed(camera_x_reg)),
        .camera_y     ($signed(camera_y_reg)),
        .camera_z     ($signed(camera_z_reg)),
        .horiz_coeffs (horiz_reg),
        .vert_coeffs  (vert_reg),
        .depth_coeffs (depth_reg),
        .focal_factor (focal_reg),
        .screen_size  (screen_reg),
        .o_ctl        (rot_ctl),
        .o_mag_x      (mag_x),
        .o_neg_x      (neg_x),
        .o_mag_y      (mag_y),
        .o_neg_y      (neg_y),
        .o_den        (den),
        .o_k          (k),
        .o_base_x     (base_x),
        .o_base_y     (base_y)
    );

    ppp_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .i_ctl    (rot_ctl),
        .i_mag_x  (mag_x),
        .i_neg_x  (neg_x),
        .i_mag_y  (mag_y),
        .i_neg_y  (neg_y),
        .i_den    (den),
        .i_k      (k),
        .i_base_x (base_x),
        .i_base_y (base_y),
        .o_ctl    (scl_ctl),
        .o_x_x    (x_x),
        .o_x_y    (x_y),
        .o_neg_x  (sneg_x),
        .o_neg_y  (sneg_y),
        .o_den    (sden)
    );

    ppp_divider u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .i_ctl   (scl_ctl),
        .i_neg   (sneg_x),
        .i_x     (x_x),
        .i_den   (sden),
        .o_ctl   (dvx_ctl),
        .o_neg   (qneg_x),
        .o_sat   (sat_x),
        .o_q     (q_x)
    );

    ppp_divider u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .i_ctl   (scl_ctl),
        .i_neg   (sneg_y),
        .i_x     (x_y),
        .i_den   (sden),
        .o_ctl   (dvy_ctl),
        .o_neg   (qneg_y),
        .o_sat   (sat_y),
        .o_q     (q_y)
    );

    // Sign and saturate the rounded quotients.
    always_comb begin
        if (qneg_x) begin
            coord_x = (sat_x || (q_x > QW'(SatMin))) ? SatMin : (32'd0 - q_x[31:0]);
        end else begin
            coord_x = (sat_x || (q_x > QW'(SatMax))) ? SatMax : q_x[31:0];
        end
        if (qneg_y) begin
            coord_y = (sat_y || (q_y > QW'(SatMin))) ? SatMin : (32'd0 - q_y[31:0]);
        end else begin
            coord_y = (sat_y || (q_y > QW'(SatMax))) ? SatMax : q_y[31:0];
        end
    end

    // Output register; points behind the camera report zero coordinates.
    always_comb begin
        m_tvalid_next = dvx_ctl.valid && dvy_ctl.valid;
        m_tuser_next  = dvx_ctl.vis && dvy_ctl.vis;
        m_tdata_next  = m_tuser_next ? {coord_y, coord_x} : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
